>>> src/rsi_pkg.sv
// Shared types and constants for the ray-sphere intersection unit.
package rsi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 4'd3;

	localparam logic [30:0] RADIUS_RST = 31'd65536;

	typedef struct packed {
		logic valid;
		logic live;
		logic sat;
	} ctl_t;

endpackage

>>> src/ray_sphere_intersect_unit.sv
// Top level of the pipelined ray-sphere intersection unit.
//
// Channel  Handshake            Payload
// in       in_valid/in_stall    origin_x/y/z, dir_x/y/z
// out      out_valid/out_stall  hit, hit_time, saturated
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One ray is accepted per cycle while in_stall is low. RW is the root width
// (39 at sixteen fraction bits), the length of the square root chain of
// one cell per root bit. The whole pipeline holds when a result is stalled
// at the output, and in_stall then rises. Reset clears the valid bits and
// returns the sphere to the unit sphere at the origin.
module ray_sphere_intersect_unit #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rsi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [31:0]            origin_x,
	input  logic signed [31:0]            origin_y,
	input  logic signed [31:0]            origin_z,
	input  logic signed [31:0]            dir_x,
	input  logic signed [31:0]            dir_y,
	input  logic signed [31:0]            dir_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [30:0]                   hit_time,
	output logic                          saturated
);

	localparam int PB_W = 65 - FRAC_BITS;
	localparam int B_W = 67 - FRAC_BITS;
	localparam int CS_W = 64 - FRAC_BITS;
	localparam int RS_W = 62 - FRAC_BITS;
	localparam int C_W = 67 - FRAC_BITS;
	localparam int H = (B_W + 1) / 2;
	localparam int QF_W = 4 * H - FRAC_BITS;
	localparam int XW = 62 + FRAC_BITS;
	localparam int RW = (XW + 1) / 2;
	localparam int XPW = 2 * RW;
	localparam int REM_W = RW + 2;
	localparam int T_W = ((B_W > RW + 1) ? B_W : RW + 1) + 1;
	localparam logic [61:0] DISC_MAX = {62{1'b1}};
	localparam logic [30:0] TIME_MAX = {31{1'b1}};

	logic signed [31:0] center_x_q, center_y_q, center_z_q;
	logic [30:0]        radius_q;
	logic               en;
	logic               out_valid_q, hit_q, saturated_q;
	logic [30:0]        hit_time_q;

	assign cfg_ready = 1'b1;
	assign en = !out_valid_q || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q <= rsi_pkg::RADIUS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rsi_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				rsi_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
				rsi_pkg::REG_CENTER_Z: center_z_q <= cfg_data;
				rsi_pkg::REG_RADIUS:   radius_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Stage 1: offsets from the center.
	rsi_pkg::ctl_t      ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic signed [32:0] d_s1 [3];
	logic signed [31:0] dir_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= 33'(origin_x) - 33'(center_x_q);
			d_s1[1] <= 33'(origin_y) - 33'(center_y_q);
			d_s1[2] <= 33'(origin_z) - 33'(center_z_q);
			dir_s1[0] <= dir_x;
			dir_s1[1] <= dir_y;
			dir_s1[2] <= dir_z;
		end
	end

	// Stage 2: products.
	logic signed [64:0] pb_s2 [3];
	logic [63:0]        pc_s2 [3];
	logic [61:0]        pr_s2;
	logic signed [32:0] dabs [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dabs[i] = d_s1[i][32] ? -d_s1[i] : d_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pb_s2[i] <= 65'(d_s1[i]) * 65'(dir_s1[i]);
				pc_s2[i] <= 64'(dabs[i][31:0]) * 64'(dabs[i][31:0]);
			end
			pr_s2 <= 62'(radius_q) * 62'(radius_q);
		end
	end

	// Stage 3: b and c.
	logic signed [PB_W-1:0] pbs [3];
	logic [CS_W-1:0]        pcs [3];
	logic [RS_W-1:0]        prs;
	logic signed [B_W-1:0]  b_s3, b_s4, b_s5, b_s6;
	logic signed [C_W-1:0]  c_s3, c_s4, c_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pbs[i] = PB_W'(pb_s2[i] >>> FRAC_BITS);
			pcs[i] = CS_W'(pc_s2[i] >> FRAC_BITS);
		end
		prs = RS_W'(pr_s2 >> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s3 <= B_W'(pbs[0]) + B_W'(pbs[1]) + B_W'(pbs[2]);
			c_s3 <= C_W'(pcs[0]) + C_W'(pcs[1]) + C_W'(pcs[2]) - C_W'(prs);
		end
	end

	// Stage 4: reject test and partial products of b squared.
	logic signed [B_W-1:0] bmag;
	logic [2*H-1:0]        magw;
	logic [2*H-1:0]        p00_s4, p01_s4, p11_s4;
	logic                  reject;

	assign bmag = b_s3[B_W-1] ? -b_s3 : b_s3;
	assign magw = (2*H)'(unsigned'(bmag));
	assign reject = (c_s3 > 0) && (b_s3 > 0);

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s4 <= magw[H-1:0] * magw[H-1:0];
			p01_s4 <= magw[H-1:0] * magw[2*H-1:H];
			p11_s4 <= magw[2*H-1:H] * magw[2*H-1:H];
			b_s4 <= b_s3;
			c_s4 <= c_s3;
		end
	end

	// Stage 5: square term with clipping.
	logic [4*H-1:0]  sq;
	logic [QF_W-1:0] qf;
	logic [61:0]     q_s5;

	assign sq = ((4*H)'(p11_s4) << (2 * H)) + ((4*H)'(p01_s4) << (H + 1))
		+ (4*H)'(p00_s4);
	assign qf = sq[4*H-1:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			q_s5 <= (qf > QF_W'(DISC_MAX)) ? DISC_MAX : qf[61:0];
			b_s5 <= b_s4;
			c_s5 <= c_s4;
		end
	end

	// Stage 6: discriminant.
	logic signed [63:0] dsum;
	logic [XPW-1:0]     x_s6;

	assign dsum = $signed({2'b00, q_s5}) - 64'(c_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s6 <= XPW'({(dsum > $signed({2'b00, DISC_MAX})) ? DISC_MAX : dsum[61:0],
				{FRAC_BITS{1'b0}}});
			b_s6 <= b_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: in_valid, live: 1'b1, sat: 1'b0};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= '{valid: ctl_s3.valid, live: !reject, sat: 1'b0};
			ctl_s5 <= '{valid: ctl_s4.valid, live: ctl_s4.live,
				sat: qf > QF_W'(DISC_MAX)};
			ctl_s6 <= '{valid: ctl_s5.valid, live: ctl_s5.live && !dsum[63],
				sat: ctl_s5.sat || (dsum > $signed({2'b00, DISC_MAX}))};
		end
	end

	// Square root chain, one cell per root bit.
	rsi_pkg::ctl_t         ch_ctl [RW+1];
	logic signed [B_W-1:0] ch_b [RW+1];
	logic [XPW-1:0]        ch_x [RW+1];
	logic [REM_W-1:0]      ch_rem [RW+1];
	logic [RW-1:0]         ch_root [RW+1];

	assign ch_ctl[0] = ctl_s6;
	assign ch_b[0] = b_s6;
	assign ch_x[0] = x_s6;
	assign ch_rem[0] = '0;
	assign ch_root[0] = '0;

	for (genvar k = 0; k < RW; k++) begin : g_cell
		rsi_sqrt_cell #(
			.RW(RW), .REM_W(REM_W), .XPW(XPW), .B_W(B_W), .IDX(RW - 1 - k)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.ctl_i(ch_ctl[k]), .b_i(ch_b[k]), .x_i(ch_x[k]),
			.rem_i(ch_rem[k]), .root_i(ch_root[k]),
			.ctl_o(ch_ctl[k+1]), .b_o(ch_b[k+1]), .x_o(ch_x[k+1]),
			.rem_o(ch_rem[k+1]), .root_o(ch_root[k+1])
		);
	end

	// Output stage: hit time with clamping.
	rsi_pkg::ctl_t     ctl_f;
	logic signed [T_W-1:0] t;

	assign ctl_f = ch_ctl[RW];
	assign t = -T_W'(ch_b[RW]) - T_W'(ch_root[RW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_f.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!ctl_f.live) begin
				hit_q <= 1'b0;
				hit_time_q <= '0;
				saturated_q <= 1'b0;
			end else if (t < 0) begin
				hit_q <= 1'b1;
				hit_time_q <= '0;
				saturated_q <= ctl_f.sat;
			end else if (t > $signed(T_W'(TIME_MAX))) begin
				hit_q <= 1'b1;
				hit_time_q <= TIME_MAX;
				saturated_q <= 1'b1;
			end else begin
				hit_q <= 1'b1;
				hit_time_q <= t[30:0];
				saturated_q <= ctl_f.sat;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign hit_time = hit_time_q;
	assign saturated = saturated_q;

endmodule

>>> src/rsi_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per ray.
module rsi_sqrt_cell #(
	parameter int RW = 39,
	parameter int REM_W = 41,
	parameter int XPW = 78,
	parameter int B_W = 51,
	parameter int IDX = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  rsi_pkg::ctl_t           ctl_i,
	input  logic signed [B_W-1:0]   b_i,
	input  logic [XPW-1:0]          x_i,
	input  logic [REM_W-1:0]        rem_i,
	input  logic [RW-1:0]           root_i,
	output rsi_pkg::ctl_t           ctl_o,
	output logic signed [B_W-1:0]   b_o,
	output logic [XPW-1:0]          x_o,
	output logic [REM_W-1:0]        rem_o,
	output logic [RW-1:0]           root_o
);

	logic [REM_W+1:0] rem_ext;
	logic [REM_W+1:0] trial;
	logic             ge;

	assign rem_ext = {rem_i, x_i[2*IDX+1 -: 2]};
	assign trial = (REM_W+2)'({root_i, 2'b01});
	assign ge = rem_ext >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_o <= b_i;
			x_o <= x_i;
			rem_o <= REM_W'(ge ? rem_ext - trial : rem_ext);
			root_o <= {root_i[RW-2:0], ge};
		end
	end

endmodule
